>>> rtl/core/pdf_pkg.sv
// shared types and constants for the packet deframer
`timescale 1ns / 1ps

package pdf_pkg;

    localparam int HEADER_BYTES_DEF = 3;
    localparam int PATTERN_W        = 24;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 16;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 56;

    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] command_code;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic [LEN_W-1:0]  payload_length;
        logic              last_payload;
        logic              checksum_error;
    } pdf_result_t;

endpackage

>>> rtl/core/pdf_parser.sv
// header hunt, length decode and checksum state machine
`timescale 1ns / 1ps

module pdf_parser
    import pdf_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic [PATTERN_W-1:0] header_pattern,
    output logic                 res_valid,
    output pdf_result_t          res
);

    localparam int WIN_W = HEADER_BYTES * BYTE_W;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_COMMAND,
        PH_TOKEN,
        PH_LENGTH,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [BYTE_W-1:0]   command_reg, command_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic                len_seen_reg, len_seen_next;

    logic [WIN_W+7:0]          shifted;
    logic [WIN_W+PATTERN_W-1:0] pattern_wide;
    logic [WIN_W-1:0]          pattern_cmp;
    logic [LEN_W:0]            count_inc;
    logic                      is_last;
    logic [LEN_W-1:0]          full_length;

    // leading header bytes beyond the register are expected to be zero
    assign shifted      = {window_reg, rx_byte};
    assign pattern_wide = {{WIN_W{1'b0}}, header_pattern};
    assign pattern_cmp  = pattern_wide[WIN_W-1:0];
    assign count_inc    = {1'b0, count_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last      = (count_inc == {1'b0, length_reg});
    assign full_length  = {length_reg[LEN_W-1:BYTE_W], rx_byte};

    always_comb begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        len_seen_next = len_seen_reg;
        res_valid     = 1'b0;
        res.result_kind    = KIND_PAYLOAD;
        res.command_code   = command_reg;
        res.payload_byte   = '0;
        res.payload_index  = '0;
        res.payload_length = length_reg;
        res.last_payload   = 1'b0;
        res.checksum_error = 1'b0;

        case (phase_reg)
            PH_COMMAND: begin
                command_next = rx_byte;
                phase_next   = PH_TOKEN;
            end
            PH_TOKEN: begin
                len_seen_next = 1'b0;
                phase_next    = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (!len_seen_reg) begin
                    length_next   = {rx_byte, {(LEN_W-BYTE_W){1'b0}}};
                    len_seen_next = 1'b1;
                end else begin
                    length_next   = full_length;
                    len_seen_next = 1'b0;
                    count_next    = '0;
                    phase_next    = (full_length != '0) ? PH_DATA : PH_CHECK;
                end
            end
            PH_DATA: begin
                res_valid         = 1'b1;
                res.payload_byte  = rx_byte;
                res.payload_index = count_reg;
                res.last_payload  = is_last;
                sum_next          = sum_reg + rx_byte;
                count_next        = count_inc[LEN_W-1:0];
                if (is_last) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK: begin
                res_valid          = 1'b1;
                res.result_kind    = KIND_COMPLETE;
                res.checksum_error = (sum_reg != rx_byte);
                window_next        = '0;
                phase_next         = PH_HUNT;
            end
            default: begin
                window_next = shifted[WIN_W-1:0];
                if (shifted[WIN_W-1:0] == pattern_cmp) begin
                    sum_next   = '0;
                    phase_next = PH_COMMAND;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            window_reg   <= '0;
            command_reg  <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            len_seen_reg <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            len_seen_reg <= len_seen_next;
        end
    end

endmodule

>>> rtl/core/pdf_out_buf.sv
// two-entry result buffer between the parser and the master port
`timescale 1ns / 1ps

module pdf_out_buf
    import pdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  pdf_result_t push_data,
    output logic        has_room,
    output logic        out_valid,
    input  logic        out_ready,
    output pdf_result_t out_data,
    output logic [1:0]  fill
);

    pdf_result_t slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign fill      = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/core/packet_deframer_with_checksum.sv
// packet deframer top level: input register, parser, result buffer
//
// channel  | dir | tdata                               | tuser       | tlast
// s_axis   | in  | rx_byte                             | -           | -
// m_axis   | out | command, byte, index, length, error | result_kind | last_payload
//
// one word accepted per cycle when the result side keeps up
// a word is held in the input register, then its result, if it produces one, is written
// to a two-entry buffer whose count register drives m_axis_tvalid
// a stalled m_axis fills the buffer, then holds the input register and s_axis_tready
// synchronous active-low reset returns the parser to header hunt with a zero window
// and clears the header pattern
`timescale 1ns / 1ps

module packet_deframer_with_checksum
    import pdf_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] command_code, [15:8] payload_byte, [31:16] payload_index,
    // [47:32] payload_length, [48] checksum_error, [55:49] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,   // [0] result_kind
    output logic                 m_axis_tlast,   // last_payload
    input  logic                 cfg_we,
    input  logic [PATTERN_W-1:0] cfg_wdata
);

    logic [PATTERN_W-1:0] pattern_reg;
    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 advance;
    logic                 res_valid;
    pdf_result_t          res;
    logic                 has_room;
    pdf_result_t          out_data;
    logic [1:0]           fill;

    assign advance       = in_valid_reg && has_room;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
        end else if (cfg_we) begin
            pattern_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    pdf_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .header_pattern (pattern_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    pdf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance && res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .fill      (fill)
    );

    assign m_axis_tdata = {7'd0, out_data.checksum_error, out_data.payload_length,
                           out_data.payload_index, out_data.payload_byte,
                           out_data.command_code};
    assign m_axis_tuser = out_data.result_kind;
    assign m_axis_tlast = out_data.last_payload;

    // input side stalls only when a word is held and the buffer is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && fill == 2'd2))
        else $error("input stalled without a full result buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill != 2'd3)
        else $error("result buffer count out of range");

    // a complete result never carries payload fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_COMPLETE) |->
        (!m_axis_tlast && m_axis_tdata[31:8] == 24'd0))
        else $error("packet complete word carries payload fields");

    // a payload word has no error flag and its index is below the length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |->
        (!m_axis_tdata[48] && m_axis_tdata[31:16] < m_axis_tdata[47:32]))
        else $error("payload word index or error flag wrong");

endmodule

>>> test/tb_top.sv
// self-checking stream testbench for the packet deframer with checksum
`timescale 1ns / 1ps

module tb_top;
    import pdf_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 40;
    localparam int PHASE_WORDS   = 220;

    typedef enum logic [2:0] {
        P_HUNT,
        P_COMMAND,
        P_TOKEN,
        P_LENGTH,
        P_DATA,
        P_CHECK
    } parse_phase_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [PATTERN_W-1:0] cfg_wdata;

    // deframer shadow state
    parse_phase_t         phase_q;
    logic [PATTERN_W-1:0] window_q;
    logic [PATTERN_W-1:0] header_q;
    logic [BYTE_W-1:0]    cmd_q;
    logic [LEN_W-1:0]     len_q;
    logic [LEN_W-1:0]     count_q;
    logic [BYTE_W-1:0]    sum_q;
    logic                 len_hi_seen;

    logic [7:0]  rx_pending[$];
    pdf_result_t predicted_words[$];

    logic s_taken = 1'b0;
    int   tx_gap = 0;
    int   tx_calm = 0;
    int   rx_stall = 0;
    int   rx_calm = 0;
    int   hold_left = 0;
    int   next_hold = 150;
    int   holds_done = 0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   words_in = 0;
    int   words_out = 0;
    int   payload_words = 0;
    int   packets_done = 0;
    int   bad_sums = 0;
    int   headers_written = 0;

    packet_deframer_with_checksum i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count,
                     predicted_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the shadow parser by one received byte
    function automatic void deframe_step(input logic [7:0] b, output logic emits,
                                         output pdf_result_t r);
        r     = '0;
        emits = 1'b0;
        case (phase_q)
            P_COMMAND: begin
                cmd_q   = b;
                phase_q = P_TOKEN;
            end
            P_TOKEN: begin
                len_hi_seen = 1'b0;
                phase_q     = P_LENGTH;
            end
            P_LENGTH: begin
                if (!len_hi_seen) begin
                    len_q       = {b, 8'h00};
                    len_hi_seen = 1'b1;
                end else begin
                    len_q[7:0]  = b;
                    len_hi_seen = 1'b0;
                    count_q     = '0;
                    phase_q     = (len_q != '0) ? P_DATA : P_CHECK;
                end
            end
            P_DATA: begin
                sum_q            = sum_q + b;
                r.result_kind    = KIND_PAYLOAD;
                r.command_code   = cmd_q;
                r.payload_byte   = b;
                r.payload_index  = count_q;
                r.payload_length = len_q;
                r.last_payload   = ({1'b0, count_q} + 17'd1) == {1'b0, len_q};
                emits            = 1'b1;
                count_q          = count_q + 16'd1;
                if (r.last_payload) phase_q = P_CHECK;
            end
            P_CHECK: begin
                r.result_kind    = KIND_COMPLETE;
                r.command_code   = cmd_q;
                r.payload_length = len_q;
                r.checksum_error = (sum_q != b);
                emits            = 1'b1;
                window_q         = '0;
                phase_q          = P_HUNT;
            end
            default: begin
                window_q = {window_q[15:0], b};
                if (window_q == header_q) begin
                    sum_q   = '0;
                    phase_q = P_COMMAND;
                end else begin
                    phase_q = P_HUNT;
                end
            end
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("mismatch at result word %0d: %s", words_out, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v) note_mismatch($sformatf("%s got %h want %h", name, got_v, want_v));
    endtask

    // sender: one word held until taken, random gaps between words
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
                s_axis_tdata  <= rx_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                if (tx_calm > 0) begin
                    tx_calm--;
                end else if ($urandom_range(0, 49) == 0) begin
                    tx_calm = $urandom_range(30, 120);
                end else begin
                    tx_gap = pick_gap();
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a few long hold-offs that back up the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (words_out >= next_hold) begin
            hold_left = HOLD_CYCLES;
            next_hold = next_hold * 3;
            holds_done++;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
                rx_calm = $urandom_range(30, 120);
            end else if ($urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : monitor
        pdf_result_t seen;
        pdf_result_t want;
        pdf_result_t predicted;
        logic        emits;
        if (!aresetn) begin
            s_taken     = 1'b0;
            phase_q     = P_HUNT;
            window_q    = '0;
            header_q    = '0;
            cmd_q       = '0;
            len_q       = '0;
            count_q     = '0;
            sum_q       = '0;
            len_hi_seen = 1'b0;
        end else begin
            s_taken = s_axis_tvalid && s_axis_tready;
            if (cfg_we) header_q = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                seen.result_kind    = m_axis_tuser;
                seen.command_code   = m_axis_tdata[7:0];
                seen.payload_byte   = m_axis_tdata[15:8];
                seen.payload_index  = m_axis_tdata[31:16];
                seen.payload_length = m_axis_tdata[47:32];
                seen.checksum_error = m_axis_tdata[48];
                seen.last_payload   = m_axis_tlast;
                if (predicted_words.size() == 0) begin
                    note_mismatch("result word with nothing expected");
                end else begin
                    want = predicted_words.pop_front();
                    check_field("result_kind", 16'(seen.result_kind),
                                16'(want.result_kind));
                    check_field("command_code", 16'(seen.command_code),
                                16'(want.command_code));
                    check_field("payload_byte", 16'(seen.payload_byte),
                                16'(want.payload_byte));
                    check_field("payload_index", seen.payload_index, want.payload_index);
                    check_field("payload_length", seen.payload_length, want.payload_length);
                    check_field("last_payload", 16'(seen.last_payload),
                                16'(want.last_payload));
                    check_field("checksum_error", 16'(seen.checksum_error),
                                16'(want.checksum_error));
                end
                if (seen.result_kind == KIND_COMPLETE) begin
                    packets_done++;
                    if (seen.checksum_error) bad_sums++;
                end else begin
                    payload_words++;
                end
                words_out++;
            end
            if (s_taken) begin
                words_in++;
                deframe_step(s_axis_tdata, emits, predicted);
                if (emits) predicted_words = {predicted_words, predicted};
            end
        end
    end

    // append one byte to the sender queue
    task automatic queue_byte(input logic [7:0] b);
        rx_pending = {rx_pending, b};
    endtask

    // push n bytes, first byte in the highest used slot
    task automatic feed_bytes(input logic [8*16-1:0] seq, input int n);
        for (int i = n - 1; i >= 0; i--) queue_byte(seq[8*i +: 8]);
    endtask

    task automatic push_packet(input logic [23:0] hdr, input int hdr_len, input int len,
                               input bit sum_ok);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] len16;
        len16 = 16'(len);
        for (int i = hdr_len - 1; i >= 0; i--) queue_byte(hdr[8*i +: 8]);
        b = 8'($urandom_range(0, 255));
        queue_byte(b);
        b = 8'($urandom_range(0, 255));
        queue_byte(b);
        queue_byte(len16[15:8]);
        queue_byte(len16[7:0]);
        sum = '0;
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            queue_byte(b);
        end
        b = sum_ok ? 8'h00 : 8'($urandom_range(1, 255));
        queue_byte(sum ^ b);
    endtask

    // mostly good packets, some line noise and corrupted headers; ends on a whole packet
    task automatic push_traffic(input logic [23:0] hdr, input int target);
        int         pushed;
        int         pick;
        int         len;
        int         hdr_len;
        logic [7:0] b;
        bit         fresh;
        pushed = 0;
        fresh  = 1'b1;
        while (pushed < target || !fresh) begin
            pick = $urandom_range(0, 99);
            // a zero header matches on one zero byte while the window is clear
            hdr_len = (fresh && hdr == 24'h0) ? 1 : 3;
            if (pick < 75 || (pushed >= target && !fresh)) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)      len = $urandom_range(0, 8);
                else if (pick < 90) len = $urandom_range(9, 40);
                else                len = $urandom_range(41, 300);
                push_packet(hdr, hdr_len, len, $urandom_range(0, 3) != 0);
                pushed += hdr_len + 5 + len;
                fresh = 1'b1;
            end else if (pick < 90 || hdr == 24'h0) begin
                repeat ($urandom_range(1, 6)) begin
                    b = 8'($urandom_range((hdr == 24'h0) ? 1 : 0, 255));
                    queue_byte(b);
                end
                fresh = 1'b0;
            end else begin
                queue_byte(hdr[23:16]);
                queue_byte(hdr[15:8]);
                b = hdr[7:0] ^ 8'($urandom_range(1, 255));
                queue_byte(b);
                fresh = 1'b0;
            end
        end
    endtask

    task automatic wait_idle();
        while (rx_pending.size() != 0 || s_axis_tvalid || predicted_words.size() != 0)
            @(posedge aclk);
        // words that produce no result may still sit in the pipe
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_header(input logic [23:0] pattern);
        @(negedge aclk);
        cfg_wdata <= pattern;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        headers_written++;
    endtask

    initial begin : stimulus
        logic [23:0] pattern;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // header still zero from reset: one zero byte opens a packet
        feed_bytes(128'({8'h00, 8'h00, 8'h5E, 8'h00, 8'h02, 8'hFF, 8'h01, 8'h00}), 8);
        // zero length goes straight to the checksum byte
        feed_bytes(128'({8'h00, 8'hFF, 8'hA1, 8'h00, 8'h00, 8'h00}), 6);
        wait_idle();
        write_header(24'hA55AC3);
        // repeated first header byte, then a bad checksum
        feed_bytes(128'({8'hA5, 8'hA5, 8'h5A, 8'hC3, 8'h80, 8'hFF, 8'h00, 8'h01, 8'h7F,
                         8'h00}), 10);
        // stop mid-packet and change the header under it
        feed_bytes(128'({8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h11}), 5);
        wait_idle();
        write_header(24'h123456);
        feed_bytes(128'({8'h00, 8'h00, 8'h01}), 3);

        push_traffic(24'h123456, PHASE_WORDS);
        wait_idle();
        write_header(24'hFFFFFF);
        push_traffic(24'hFFFFFF, PHASE_WORDS);
        wait_idle();
        write_header(24'h000000);
        push_traffic(24'h000000, PHASE_WORDS);
        pattern = 24'($urandom_range(1, 24'hFFFFFF));
        wait_idle();
        write_header(pattern);
        push_traffic(pattern, PHASE_WORDS);
        wait_idle();

        if (predicted_words.size() != 0)
            note_mismatch($sformatf("%0d result words never arrived", predicted_words.size()));
        $display("covered %0d input words -> %0d payload words, %0d packets (%0d bad checksum)",
                 words_in, payload_words, packets_done, bad_sums);
        $display("%0d header settings, %0d receiver hold-offs, %0d mismatches",
                 headers_written, holds_done, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
